/* sv/sfd_pkg.sv */
// Shared types, constants and the CRC-8 step for the short frame decoder.
package sfd_pkg;

   localparam logic [5:0] FRAME_MARK  = 6'h1e;
   localparam logic [7:0] CRC_POLY    = 8'h07;
   localparam logic [7:0] CRC_INIT    = 8'h00;
   localparam int         STORE_DEPTH = 15;
   localparam int         IDX_W       = 4;

   // register indexes on the csr port
   localparam logic       CSR_KEEPALIVE = 1'b0;
   localparam logic       CSR_MASK      = 1'b1;

   typedef enum logic [2:0] {
      ST_PAYLOAD   = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_MARK_ERR  = 3'd2,
      ST_CRC_ERR   = 3'd3,
      ST_UNHANDLED = 3'd4
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic       hdr0_load;
      logic       hdr1_load;
      logic       data_load;
      logic       emit_init;
      logic       emit_load;
      logic       single_load;
      status_type single_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic mark_ok;
      logic new_size_zero;
      logic size_zero;
      logic data_done;
      logic crc_ok;
      logic keepalive;
      logic handled;
      logic emit_last;
      logic out_free;
   } stat_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (r[7]) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

/* sv/sfd_ctrl.sv */
// Frame parsing state machine: sequences header, payload, CRC check and payload replay.
module sfd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  sfd_pkg::stat_type stat,
   output sfd_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_HDR0 = 5'b00001,
      S_HDR1 = 5'b00010,
      S_DATA = 5'b00100,
      S_CRC  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = stat.out_free && (state_ff != S_EMIT);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      cmd.single_status = sfd_pkg::ST_PAYLOAD;
      unique case (state_ff)
         S_HDR0: begin
            if (accept) begin
               if (stat.mark_ok) begin
                  cmd.hdr0_load = 1'b1;
                  state_in      = S_HDR1;
               end else begin
                  cmd.single_load   = 1'b1;
                  cmd.single_status = sfd_pkg::ST_MARK_ERR;
               end
            end
         end
         S_HDR1: begin
            if (accept) begin
               cmd.hdr1_load = 1'b1;
               state_in      = stat.new_size_zero ? S_CRC : S_DATA;
            end
         end
         S_DATA: begin
            if (accept) begin
               cmd.data_load = 1'b1;
               if (stat.data_done) begin
                  state_in = S_CRC;
               end
            end
         end
         S_CRC: begin
            if (accept) begin
               state_in = S_HDR0;
               priority if (stat.keepalive) begin
               end else if (!stat.crc_ok) begin
                  cmd.single_load   = 1'b1;
                  cmd.single_status = sfd_pkg::ST_CRC_ERR;
               end else if (!stat.handled) begin
                  cmd.single_load   = 1'b1;
                  cmd.single_status = sfd_pkg::ST_UNHANDLED;
               end else if (stat.size_zero) begin
                  cmd.single_load   = 1'b1;
                  cmd.single_status = sfd_pkg::ST_EMPTY;
               end else begin
                  cmd.emit_init = 1'b1;
                  state_in      = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_load = 1'b1;
               if (stat.emit_last) begin
                  state_in = S_HDR0;
               end
            end
         end
         default: begin
            state_in = S_HDR0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HDR0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/sfd_dpath.sv */
// Datapath: header fields, CRC accumulator, payload store, config registers, result register.
module sfd_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           rx_byte,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata,
   input  sfd_pkg::cmd_type      cmd,
   output sfd_pkg::stat_type     stat,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output sfd_pkg::status_type   rsp_status,
   output logic [3:0]           rsp_frame_type,
   output logic [1:0]           rsp_seq_number,
   output logic [7:0]           rsp_data_byte,
   output logic [3:0]           rsp_byte_index,
   output logic                 rsp_last
);

   logic [3:0]  keepalive_ff;
   logic [15:0] mask_ff;
   logic [3:0]  size_ff;
   logic [1:0]  seq_ff;
   logic [3:0]  type_ff;
   logic [sfd_pkg::IDX_W-1:0] count_ff;
   logic [sfd_pkg::IDX_W-1:0] emit_idx_ff;
   logic [7:0]  crc_ff;
   logic [7:0]  store_ff [sfd_pkg::STORE_DEPTH];
   logic [3:0]  new_size;
   logic [sfd_pkg::IDX_W-1:0] count_inc;
   logic [sfd_pkg::IDX_W-1:0] emit_inc;

   logic                valid_ff;
   sfd_pkg::status_type status_ff;
   logic [3:0]          otype_ff;
   logic [1:0]          oseq_ff;
   logic [7:0]          odata_ff;
   logic [3:0]          oidx_ff;
   logic                olast_ff;

   assign new_size  = size_ff | {2'b00, rx_byte[7:6]};
   assign count_inc = count_ff + 1'b1;
   assign emit_inc  = emit_idx_ff + 1'b1;

   always_comb begin
      stat               = '0;
      stat.mark_ok       = (rx_byte[7:2] == sfd_pkg::FRAME_MARK);
      stat.new_size_zero = (new_size == 4'd0);
      stat.size_zero     = (size_ff == 4'd0);
      stat.data_done     = (count_inc >= size_ff);
      stat.crc_ok        = (crc_ff == rx_byte);
      stat.keepalive     = (type_ff == keepalive_ff);
      stat.handled       = mask_ff[type_ff];
      stat.emit_last     = (emit_inc == size_ff);
      stat.out_free      = !valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keepalive_ff <= '0;
         mask_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sfd_pkg::CSR_KEEPALIVE: keepalive_ff <= csr_wdata[3:0];
            sfd_pkg::CSR_MASK:      mask_ff      <= csr_wdata;
            default:                ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= '0;
         seq_ff      <= '0;
         type_ff     <= '0;
         count_ff    <= '0;
         crc_ff      <= sfd_pkg::CRC_INIT;
         emit_idx_ff <= '0;
      end else begin
         if (cmd.hdr0_load) begin
            size_ff <= {rx_byte[1:0], 2'b00};
         end
         if (cmd.hdr1_load) begin
            size_ff  <= new_size;
            seq_ff   <= rx_byte[5:4];
            type_ff  <= rx_byte[3:0];
            count_ff <= '0;
            crc_ff   <= sfd_pkg::CRC_INIT;
         end
         if (cmd.data_load) begin
            crc_ff   <= sfd_pkg::crc8_update(crc_ff, rx_byte);
            count_ff <= count_inc;
         end
         if (cmd.emit_init) begin
            emit_idx_ff <= '0;
         end else if (cmd.emit_load) begin
            emit_idx_ff <= emit_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.data_load && (count_ff < 4'(sfd_pkg::STORE_DEPTH))) begin
         store_ff[count_ff] <= rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.single_load || cmd.emit_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.single_load) begin
         status_ff <= cmd.single_status;
         if (cmd.single_status == sfd_pkg::ST_MARK_ERR) begin
            otype_ff <= '0;
            oseq_ff  <= '0;
         end else begin
            otype_ff <= type_ff;
            oseq_ff  <= seq_ff;
         end
         odata_ff <= '0;
         oidx_ff  <= '0;
         olast_ff <= 1'b1;
      end else if (cmd.emit_load) begin
         status_ff <= sfd_pkg::ST_PAYLOAD;
         otype_ff  <= type_ff;
         oseq_ff   <= seq_ff;
         odata_ff  <= store_ff[emit_idx_ff];
         oidx_ff   <= emit_idx_ff;
         olast_ff  <= stat.emit_last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_frame_type = otype_ff;
   assign rsp_seq_number = oseq_ff;
   assign rsp_data_byte  = odata_ff;
   assign rsp_byte_index = oidx_ff;
   assign rsp_last       = olast_ff;

endmodule

/* sv/short_frame_decoder_crc8.sv */
// Top level of the short frame decoder with CRC-8 check.
//
// req_*: one received byte per transfer. rsp_*: decoded results, tuser carries
// the status, tlast marks the final result of a frame's run. csr_*: register
// writes (index 0 keepalive type, index 1 handler mask), taken at any edge with
// csr_we high; the user is to write them only while idle, which the block does not enforce.
// Header, payload and CRC bytes are taken at one byte per cycle while the result
// register is free; a byte that produces a single result (mark error, CRC error,
// unhandled type, empty frame) shows its result the cycle after acceptance.
// A good handled frame of N payload bytes replays them from the 15-entry
// payload store, one result per cycle while rsp_tready is high, so req_tready
// is low while the payload is replayed. The single result register sets the
// rate of that burst.
// Reset returns to hunting for a first header byte, clears both registers and
// the result valid. When rsp_tready is low the result register holds, and
// req_tready drops as soon as a new result would be needed; bytes that give no
// result are also held off until the result register is free.
module short_frame_decoder_crc8 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] frame_type, [5:4] seq_number,
                                    // [13:6] data_byte, [17:14] byte_index, zero fill
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   sfd_pkg::cmd_type    cmd;
   sfd_pkg::stat_type   stat;
   sfd_pkg::status_type status;
   logic [3:0]          frame_type;
   logic [1:0]          seq_number;
   logic [7:0]          data_byte;
   logic [3:0]          byte_index;

   sfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfd_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_status     (status),
      .rsp_frame_type (frame_type),
      .rsp_seq_number (seq_number),
      .rsp_data_byte  (data_byte),
      .rsp_byte_index (byte_index),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {6'b000000, byte_index, data_byte, seq_number, frame_type};
   assign rsp_tuser = status;

endmodule
